// ----- hw/rtl/pidaw_pkg.sv -----
`timescale 1ns / 1ps
package pidaw_pkg;

  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int SumWidthDef  = 48;

  localparam int CfgIndexWidth = 8;
  localparam int RateWidth     = 16;
  localparam int SmoothWidth   = 17;

  // function codes carried in tuser
  localparam logic [1:0] FUNC_ITERATE = 2'd0;
  localparam logic [1:0] FUNC_INIT    = 2'd1;
  localparam logic [1:0] FUNC_SEED    = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;  // unused code, no state change

  // register indexes
  localparam logic [CfgIndexWidth-1:0] REG_PROP_GAIN     = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_INTEG_GAIN    = 8'd1;
  localparam logic [CfgIndexWidth-1:0] REG_DERIV_GAIN    = 8'd2;
  localparam logic [CfgIndexWidth-1:0] REG_CLAMP_ENABLE  = 8'd3;
  localparam logic [CfgIndexWidth-1:0] REG_CLAMP_LOW     = 8'd4;
  localparam logic [CfgIndexWidth-1:0] REG_CLAMP_HIGH    = 8'd5;
  localparam logic [CfgIndexWidth-1:0] REG_FILTER_ENABLE = 8'd6;
  localparam logic [CfgIndexWidth-1:0] REG_SMOOTHING     = 8'd7;

  // post-multiply shift selection
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_FRAC = 2'd1;
  localparam logic [1:0] SH_Q16  = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] shift;
    logic       sat_sum;  // saturate to sum width instead of data width
  } mul_ctl_t;

endpackage

// ----- hw/rtl/pidaw_mul.sv -----
`timescale 1ns / 1ps
module pidaw_mul #(
  parameter int DATA_WIDTH = pidaw_pkg::DataWidthDef,
  parameter int FRAC_BITS  = pidaw_pkg::FracBitsDef,
  parameter int SUM_WIDTH  = pidaw_pkg::SumWidthDef,
  parameter int MW         = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidaw_pkg::mul_ctl_t ctl_i,
  input  logic signed [MW:0]  a_i,
  input  logic signed [MW:0]  b_i,
  output logic                done_o,
  output logic [MW-1:0]       res_o
);
  import pidaw_pkg::*;

  localparam int NC  = (MW + 15) / 16;
  localparam int BW  = NC * 16;
  localparam int PW  = MW + BW;
  localparam int CW  = $clog2(NC + 1);
  localparam int SHW = $clog2((FRAC_BITS > 16 ? FRAC_BITS : 16) + 1);

  logic [MW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [PW-1:0] acc_q, acc_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, neg_q, done_q;
  logic [1:0]    shift_q;
  logic          sat_sum_q;
  logic [MW-1:0] res_q, res_d;

  logic [MW+15:0] prod;
  logic [MW-1:0]  a_mag, b_mag;
  logic [SHW-1:0] shamt;
  logic [PW-1:0]  shifted, top_bit, lim, m;

  assign a_mag = a_i[MW] ? MW'(-a_i) : MW'(a_i);
  assign b_mag = b_i[MW] ? MW'(-b_i) : MW'(b_i);

  // 16 bits of b per cycle, accumulated from the low chunk up
  assign prod  = (MW + 16)'(a_q) * (MW + 16)'(b_q[15:0]);
  assign acc_d = (acc_q >> 16) + (PW'(prod) << (BW - 16));

  always_comb begin
    case (shift_q)
      SH_FRAC: shamt = SHW'(FRAC_BITS);
      SH_Q16:  shamt = SHW'(16);
      default: shamt = '0;
    endcase
  end

  assign shifted = acc_q >> shamt;
  assign top_bit = sat_sum_q ? (PW'(1) << (SUM_WIDTH - 1)) : (PW'(1) << (DATA_WIDTH - 1));
  assign lim     = top_bit - PW'(!neg_q);
  assign m       = (shifted > lim) ? lim : shifted;
  assign res_d   = neg_q ? MW'(-m) : MW'(m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NC)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q       <= a_mag;
      b_q       <= BW'(b_mag);
      acc_q     <= '0;
      neg_q     <= a_i[MW] ^ b_i[MW];
      shift_q   <= ctl_i.shift;
      sat_sum_q <= ctl_i.sat_sum;
    end else if (busy_q && cnt_q != CW'(NC)) begin
      acc_q <= acc_d;
      b_q   <= b_q >> 16;
    end
    if (busy_q && cnt_q == CW'(NC)) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

// ----- hw/rtl/pidaw_div.sv -----
`timescale 1ns / 1ps
module pidaw_div #(
  parameter int DATA_WIDTH = pidaw_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DATA_WIDTH:0]   num_i,
  input  logic [pidaw_pkg::RateWidth-1:0] den_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] quo_o
);
  import pidaw_pkg::*;

  localparam int NW = DATA_WIDTH + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]        n_q;
  logic [RateWidth-1:0] rem_q, den_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, neg_q, done_q;
  logic [DATA_WIDTH-1:0] quo_q;

  logic [RateWidth:0]   trial;
  logic                 fits;
  logic [NW-1:0]        qmag;
  logic [DATA_WIDTH-1:0] lim, qsat;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, n_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign qmag  = n_q;
  assign lim   = {1'b0, {(DATA_WIDTH-1){1'b1}}} + DATA_WIDTH'(neg_q);
  assign qsat  = (qmag > NW'(lim)) ? lim : DATA_WIDTH'(qmag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NW)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i[DATA_WIDTH] ? NW'(-num_i) : NW'(num_i);
      neg_q <= num_i[DATA_WIDTH];
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q && cnt_q != CW'(NW)) begin
      rem_q <= fits ? RateWidth'(trial - {1'b0, den_q}) : RateWidth'(trial);
      n_q   <= {n_q[NW-2:0], fits};
    end
    if (busy_q && cnt_q == CW'(NW)) quo_q <= neg_q ? DATA_WIDTH'(-qsat) : qsat;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ----- hw/rtl/pid_antiwindup_filtered_derivative.sv -----
`timescale 1ns / 1ps
// PID controller with conditional-integration anti-windup and an optional moving
// average on the derivative, signed fixed point with saturation. One item is
// taken at a time; s_axis_tready is high only while the sequencer is idle. Every
// item first runs the serial divider for the error rate, then an iterate item
// runs four or, with filtering, six products on one shared multiplier that
// consumes 16 multiplier bits per cycle (MW, its operand width, the widest of
// data, sum and 17 bits). An item's result waits in S_OUT until the output
// register is free. One result follows each item through an output register.
module pid_antiwindup_filtered_derivative #(
  parameter int DATA_WIDTH = pidaw_pkg::DataWidthDef,
  parameter int FRAC_BITS  = pidaw_pkg::FracBitsDef,
  parameter int SUM_WIDTH  = pidaw_pkg::SumWidthDef,
  localparam int IDW = ((2 * DATA_WIDTH + 16 + 7) / 8) * 8,
  localparam int ODW = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int CDW = DATA_WIDTH > 17 ? DATA_WIDTH : 17
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pidaw_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CDW-1:0]                      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [IDW-1:0]                      s_axis_tdata,  // measured, target, elapsed_ms
  input  logic [1:0]                          s_axis_tuser,  // func
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ODW-1:0]                      m_axis_tdata,  // drive
  output logic                                m_axis_tuser   // integrating
);
  import pidaw_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int SW  = SUM_WIDTH;
  localparam int MW0 = DW > SW ? DW : SW;
  localparam int MW  = MW0 > 17 ? MW0 : 17;
  localparam int XW  = MW + 2;

  localparam logic signed [XW-1:0] DMAX = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [XW-1:0] SMAX = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_MP    = 4'd2;
  localparam logic [3:0] S_MET   = 4'd3;
  localparam logic [3:0] S_MI    = 4'd4;
  localparam logic [3:0] S_CLAMP = 4'd5;
  localparam logic [3:0] S_MA1   = 4'd6;
  localparam logic [3:0] S_MA2   = 4'd7;
  localparam logic [3:0] S_MD    = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  function automatic logic signed [XW-1:0] clip(input logic signed [XW-1:0] x,
                                                input logic signed [XW-1:0] mx);
    clip = (x > mx) ? mx : ((x < ~mx) ? ~mx : x);
  endfunction

  // configuration
  logic signed [DW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, clamp_low_q, clamp_high_q;
  logic                 clamp_en_q, filter_en_q;
  logic [SmoothWidth-1:0] smoothing_q;

  // state
  logic signed [SW-1:0] error_sum_q;
  logic signed [DW-1:0] last_error_q, rate_avg_q, held_drive_q;

  // per-item working registers
  logic [3:0]           st_q;
  logic                 go_q;
  logic [1:0]           func_q;
  logic signed [DW-1:0] err_q, rate_q, p_q, i_q, a1_q;
  logic [RateWidth-1:0] dt_q;
  logic signed [SW-1:0] total_q;
  logic signed [XW-1:0] sum_q;
  logic                 integ_q;

  logic                 out_valid_q, out_integ_q;
  logic signed [DW-1:0] out_drive_q;

  logic                 in_xfer, out_free;
  logic signed [DW-1:0] meas_in, targ_in;
  logic [RateWidth-1:0] dt_in;
  logic signed [XW-1:0] err_wide;

  mul_ctl_t             mctl;
  logic signed [MW:0]   ma, mb;
  logic                 mdone, ddone;
  logic [MW-1:0]        mres;
  logic signed [DW-1:0] rate_res, mres_d;
  logic signed [SW-1:0] mres_s;
  logic [SmoothWidth-1:0] s_eff, s_inv;

  logic signed [XW-1:0] total_w, init_w, pi_w, avg_w, drive_w;
  logic                 hold;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign meas_in  = s_axis_tdata[DW-1:0];
  assign targ_in  = s_axis_tdata[2*DW-1:DW];
  assign dt_in    = s_axis_tdata[2*DW+15:2*DW];
  assign err_wide = clip(XW'(targ_in) - XW'(meas_in), DMAX);

  assign mres_d = DW'(mres);
  assign mres_s = SW'(mres);

  assign s_eff = (smoothing_q > SmoothWidth'(65536)) ? SmoothWidth'(65536) : smoothing_q;
  assign s_inv = SmoothWidth'(65536) - s_eff;

  // operand selection for the shared multiplier
  always_comb begin
    mctl.start   = go_q && (st_q == S_MP || st_q == S_MET || st_q == S_MI ||
                            st_q == S_MA1 || st_q == S_MA2 || st_q == S_MD);
    mctl.shift   = SH_FRAC;
    mctl.sat_sum = 1'b0;
    ma = (MW + 1)'(prop_gain_q);
    mb = (MW + 1)'(err_q);
    case (st_q)
      S_MET: begin
        ma = (MW + 1)'(err_q);
        mb = (MW + 1)'($signed({1'b0, dt_q}));
        mctl.shift   = SH_NONE;
        mctl.sat_sum = 1'b1;
      end
      S_MI: begin
        ma = (MW + 1)'(integ_gain_q);
        mb = (MW + 1)'(total_q);
      end
      S_MA1: begin
        ma = (MW + 1)'(rate_avg_q);
        mb = (MW + 1)'($signed({1'b0, s_inv}));
        mctl.shift = SH_Q16;
      end
      S_MA2: begin
        ma = (MW + 1)'(rate_q);
        mb = (MW + 1)'($signed({1'b0, s_eff}));
        mctl.shift = SH_Q16;
      end
      S_MD: begin
        ma = (MW + 1)'(deriv_gain_q);
        mb = filter_en_q ? (MW + 1)'(rate_avg_q) : (MW + 1)'(rate_q);
      end
      default: ;
    endcase
  end

  pidaw_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .SUM_WIDTH (SUM_WIDTH),
    .MW        (MW)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mctl),
    .a_i   (ma),
    .b_i   (mb),
    .done_o(mdone),
    .res_o (mres)
  );

  pidaw_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(go_q && st_q == S_DIV),
    .num_i  ((DW + 1)'(err_q) - (DW + 1)'(last_error_q)),
    .den_i  (dt_q),
    .done_o (ddone),
    .quo_o  (rate_res)
  );

  assign total_w = clip(XW'(error_sum_q) + XW'(mres_s), SMAX);
  assign init_w  = clip(XW'(error_sum_q) + clip(XW'(err_q), SMAX), SMAX);
  assign pi_w    = XW'(p_q) + XW'(i_q);
  assign hold    = clamp_en_q && (clamp_low_q < clamp_high_q) &&
                   (pi_w <= XW'(clamp_low_q) || pi_w >= XW'(clamp_high_q)) &&
                   (p_q[DW-1] == err_q[DW-1]);
  assign avg_w   = clip(XW'(a1_q) + XW'(mres_d), DMAX);
  assign drive_w = clip(sum_q + XW'(mres_d), DMAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
      clamp_en_q   <= 1'b0;
      clamp_low_q  <= '0;
      clamp_high_q <= '0;
      filter_en_q  <= 1'b0;
      smoothing_q  <= '0;
      error_sum_q  <= '0;
      last_error_q <= '0;
      rate_avg_q   <= '0;
      held_drive_q <= '0;
      st_q         <= S_IDLE;
      go_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PROP_GAIN:     prop_gain_q  <= cfg_data_i[DW-1:0];
          REG_INTEG_GAIN:    integ_gain_q <= cfg_data_i[DW-1:0];
          REG_DERIV_GAIN:    deriv_gain_q <= cfg_data_i[DW-1:0];
          REG_CLAMP_ENABLE:  clamp_en_q   <= cfg_data_i[0];
          REG_CLAMP_LOW:     clamp_low_q  <= cfg_data_i[DW-1:0];
          REG_CLAMP_HIGH:    clamp_high_q <= cfg_data_i[DW-1:0];
          REG_FILTER_ENABLE: filter_en_q  <= cfg_data_i[0];
          REG_SMOOTHING:     smoothing_q  <= cfg_data_i[SmoothWidth-1:0];
          default: ;
        endcase
      end
      if (st_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        S_IDLE: begin
          if (in_xfer) begin
            st_q <= S_DIV;
            go_q <= 1'b1;
          end
        end
        S_DIV: begin
          if (ddone) begin
            if (func_q == FUNC_ITERATE) begin
              st_q <= S_MP;
              go_q <= 1'b1;
            end else begin
              if (func_q == FUNC_INIT) begin
                error_sum_q  <= SW'(init_w);
                last_error_q <= err_q;
              end else if (func_q == FUNC_SEED) begin
                rate_avg_q <= rate_res;
              end
              st_q <= S_OUT;
            end
          end
        end
        S_MP:  if (mdone) begin st_q <= S_MET; go_q <= 1'b1; end
        S_MET: if (mdone) begin st_q <= S_MI;  go_q <= 1'b1; end
        S_MI:  if (mdone) st_q <= S_CLAMP;
        S_CLAMP: begin
          if (!hold) error_sum_q <= total_q;
          st_q <= filter_en_q ? S_MA1 : S_MD;
          go_q <= 1'b1;
        end
        S_MA1: if (mdone) begin st_q <= S_MA2; go_q <= 1'b1; end
        S_MA2: begin
          if (mdone) begin
            rate_avg_q <= DW'(avg_w);
            st_q       <= S_MD;
            go_q       <= 1'b1;
          end
        end
        S_MD: begin
          if (mdone) begin
            held_drive_q <= DW'(drive_w);
            last_error_q <= err_q;
            st_q         <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      err_q   <= DW'(err_wide);
      dt_q    <= (dt_in == '0) ? RateWidth'(1) : dt_in;
      func_q  <= s_axis_tuser;
      integ_q <= 1'b0;
    end
    if (st_q == S_DIV && ddone) rate_q <= rate_res;
    if (st_q == S_MP && mdone) p_q <= mres_d;
    if (st_q == S_MET && mdone) total_q <= SW'(total_w);
    if (st_q == S_MI && mdone) i_q <= mres_d;
    if (st_q == S_CLAMP) begin
      sum_q   <= hold ? XW'(p_q) : pi_w;
      integ_q <= !hold;
    end
    if (st_q == S_MA1 && mdone) a1_q <= mres_d;
    if (st_q == S_OUT && out_free) begin
      out_drive_q <= held_drive_q;
      out_integ_q <= (func_q == FUNC_ITERATE) && integ_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'($unsigned(out_drive_q));
  assign m_axis_tuser  = out_integ_q;
endmodule

// ----- hw/rtl/pidaw_checker.sv -----
`timescale 1ns / 1ps
module pidaw_checker #(
  parameter int ODW = 32
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [ODW-1:0] m_axis_tdata,
  input logic           m_axis_tuser,
  input logic           cfg_ready_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // a new result only comes out of a busy sequencer
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without an item in progress");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind pid_antiwindup_filtered_derivative pidaw_checker #(
  .ODW(ODW)
) u_pidaw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .cfg_ready_o  (cfg_ready_o)
);
